@@ src/hqs_pkg.sv @@
// hqs_pkg: shared types, constants and the order compare for the quicksort engine.
// No dependencies; used by hqs_sorter and hybrid_quicksort_engine.
package hqs_pkg;

    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SORT,
        S_DRAIN
    } t_top_state;

    typedef enum logic [4:0] {
        SS_IDLE,
        SS_LOOP,
        SS_POP,
        SS_P_RDP,
        SS_P_LDP,
        SS_P_RDJ,
        SS_P_CMP,
        SS_P_SW1,
        SS_P_SW2,
        SS_F_RD,
        SS_F_SW1,
        SS_F_SW2,
        SS_SPLIT,
        SS_I_RDK,
        SS_I_LDK,
        SS_I_RDJ,
        SS_I_CMP,
        SS_I_WR
    } t_sort_state;

    // true when a must come after b in the selected order
    function automatic logic out_of_order(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b,
        input logic                    desc
    );
        out_of_order = desc ? (a < b) : (a > b);
    endfunction

endpackage

@@ src/hybrid_quicksort_engine.sv @@
// hybrid_quicksort_engine: top level; load, sort and drain of one array.
// Depends on hqs_pkg, hqs_ram and hqs_sorter.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one signed 32-bit value per
//   request, with i_last_in on the final element. Requests are taken one
//   per cycle while loading; values past MAX_ELEMENTS are dropped, but a
//   dropped request marked last still starts the sort.
//   After the last request o_ready drops. A sequencer sorts the store
//   with one comparator and one RAM port: Lomuto quicksort with the last
//   element as pivot, ranges of INSERTION_CUTOFF or fewer finished by
//   insertion sort, smaller side pushed on a STACK_DEPTH range stack.
//   Sort time is set by that single RAM port: of order N log N element
//   visits typically, N squared at worst. Output channel (o_valid/i_ready)
//   then returns the N sorted values, o_last_out on the final one; the next
//   value is read from the store only once the previous one has moved to
//   the output register. A stalled receiver just holds the output register;
//   loading of the next array starts once the last result sits there.
//   i_cfg_we/i_cfg_data write the order bit (1 = descending) while idle.
//   Synchronous active-low reset: empty store, loading, order ascending.
module hybrid_quicksort_engine #(
    parameter int MAX_ELEMENTS     = 64,
    parameter int INSERTION_CUTOFF = 10,
    parameter int STACK_DEPTH      = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [hqs_pkg::VAL_W-1:0] i_value,
    input  logic                             i_last_in,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [hqs_pkg::VAL_W-1:0] o_sorted_value,
    output logic                             o_last_out,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_data
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_ELEMENTS);

    hqs_pkg::t_top_state r_state, n_state;

    logic          r_desc;
    logic [CW-1:0] r_cnt, n_cnt;        // elements in the store
    logic          r_start, n_start;    // one-cycle kick to the sorter
    logic [CW-1:0] r_rd_idx, n_rd_idx;  // next drain read
    logic          r_pend, n_pend;      // drain read in flight
    logic          r_pend_last, n_pend_last;
    logic          r_all, n_all;        // every drain read issued
    logic          r_ovalid, n_ovalid;
    logic signed [hqs_pkg::VAL_W-1:0] r_oval, n_oval;
    logic          r_olast, n_olast;

    logic                             in_acc;
    logic                             load_we;
    logic                             drain_re;
    logic                             sort_done;
    logic                             sort_re, sort_we;
    logic [AW-1:0]                    sort_raddr, sort_waddr;
    logic signed [hqs_pkg::VAL_W-1:0] sort_wdata;
    logic                             ram_we, ram_re;
    logic [AW-1:0]                    ram_waddr, ram_raddr;
    logic signed [hqs_pkg::VAL_W-1:0] ram_wdata, ram_rdata;

    assign o_ready        = (r_state == hqs_pkg::S_LOAD);
    assign in_acc         = i_valid && o_ready;
    assign o_valid        = r_ovalid;
    assign o_sorted_value = r_oval;
    assign o_last_out     = r_olast;

    // RAM port sharing: load writes, drain reads, sorter otherwise
    assign ram_we    = load_we || sort_we;
    assign ram_waddr = (r_state == hqs_pkg::S_LOAD) ? AW'(r_cnt) : sort_waddr;
    assign ram_wdata = (r_state == hqs_pkg::S_LOAD) ? i_value : sort_wdata;
    assign ram_re    = drain_re || sort_re;
    assign ram_raddr = (r_state == hqs_pkg::S_DRAIN) ? AW'(r_rd_idx) : sort_raddr;

    hqs_ram #(
        .WIDTH (hqs_pkg::VAL_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hqs_sorter #(
        .MAX_ELEMENTS     (MAX_ELEMENTS),
        .INSERTION_CUTOFF (INSERTION_CUTOFF),
        .STACK_DEPTH      (STACK_DEPTH)
    ) u_sorter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_count     (r_cnt),
        .i_desc      (r_desc),
        .o_done      (sort_done),
        .o_ram_re    (sort_re),
        .o_ram_raddr (sort_raddr),
        .i_ram_rdata (ram_rdata),
        .o_ram_we    (sort_we),
        .o_ram_waddr (sort_waddr),
        .o_ram_wdata (sort_wdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hqs_pkg::S_LOAD;
            r_desc   <= 1'b0;
            r_cnt    <= '0;
            r_start  <= 1'b0;
            r_pend   <= 1'b0;
            r_all    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_start  <= n_start;
            r_pend   <= n_pend;
            r_all    <= n_all;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_desc <= i_cfg_data;
            end
        end
        r_rd_idx    <= n_rd_idx;
        r_pend_last <= n_pend_last;
        r_oval      <= n_oval;
        r_olast     <= n_olast;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_start     = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_all       = r_all;
        n_ovalid    = r_ovalid && !i_ready;
        n_oval      = r_oval;
        n_olast     = r_olast;
        load_we     = 1'b0;
        drain_re    = 1'b0;

        case (r_state)
            hqs_pkg::S_LOAD: begin
                if (in_acc) begin
                    if (r_cnt < MAXC) begin
                        load_we = 1'b1;
                        n_cnt   = r_cnt + 1'b1;
                    end
                    if (i_last_in) begin
                        n_start = 1'b1;
                        n_state = hqs_pkg::S_SORT;
                    end
                end
            end
            hqs_pkg::S_SORT: begin
                if (sort_done) begin
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                    n_all    = 1'b0;
                    n_state  = hqs_pkg::S_DRAIN;
                end
            end
            hqs_pkg::S_DRAIN: begin
                if (!r_pend && !r_all) begin
                    drain_re    = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = (r_rd_idx == r_cnt - 1'b1);
                    n_all       = (r_rd_idx == r_cnt - 1'b1);
                    n_rd_idx    = r_rd_idx + 1'b1;
                end
                // read data holds in the RAM until the output slot frees
                if (r_pend && (!r_ovalid || i_ready)) begin
                    n_pend   = 1'b0;
                    n_ovalid = 1'b1;
                    n_oval   = ram_rdata;
                    n_olast  = r_pend_last;
                    if (r_pend_last) begin
                        n_cnt   = '0;
                        n_state = hqs_pkg::S_LOAD;
                    end
                end
            end
            default: begin
                n_state = hqs_pkg::S_LOAD;
            end
        endcase
    end

endmodule

@@ src/hqs_ram.sv @@
// hqs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module hqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/hqs_sorter.sv @@
// hqs_sorter: sequencer for the hybrid quicksort over the element RAM.
// Depends on hqs_pkg; drives the RAM ports owned by the top level.
module hqs_sorter #(
    parameter int MAX_ELEMENTS     = 64,
    parameter int INSERTION_CUTOFF = 10,
    parameter int STACK_DEPTH      = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [$clog2(MAX_ELEMENTS+1)-1:0]     i_count,
    input  logic                                  i_desc,
    output logic                                  o_done,
    output logic                                  o_ram_re,
    output logic [$clog2(MAX_ELEMENTS)-1:0]       o_ram_raddr,
    input  logic signed [hqs_pkg::VAL_W-1:0]      i_ram_rdata,
    output logic                                  o_ram_we,
    output logic [$clog2(MAX_ELEMENTS)-1:0]       o_ram_waddr,
    output logic signed [hqs_pkg::VAL_W-1:0]      o_ram_wdata
);

    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int CUT_W = $clog2(INSERTION_CUTOFF + 1);
    localparam int XW    = (AW > CUT_W) ? AW : CUT_W;
    localparam int SW    = $clog2(STACK_DEPTH + 1);
    localparam int SIW   = $clog2(STACK_DEPTH);
    localparam logic [XW-1:0] CUT    = XW'(INSERTION_CUTOFF);
    localparam logic [SW-1:0] SDEPTH = SW'(STACK_DEPTH);

    hqs_pkg::t_sort_state r_state, n_state;

    logic [AW-1:0] r_lo, n_lo, r_hi, n_hi;       // current quicksort range
    logic [AW-1:0] r_ilo, n_ilo, r_ihi, n_ihi;   // insertion range
    logic [AW-1:0] r_i, n_i, r_jp, n_jp;         // insertion cursor, hole
    logic [AW-1:0] r_j, n_j, r_ip, n_ip;         // partition scan, store slot
    logic signed [hqs_pkg::VAL_W-1:0] r_pivot, n_pivot;
    logic signed [hqs_pkg::VAL_W-1:0] r_key, n_key;
    logic signed [hqs_pkg::VAL_W-1:0] r_val, n_val;
    logic          r_resume, n_resume;           // insertion returns to the loop
    logic [SW-1:0] r_sp, n_sp;
    logic [AW-1:0] r_stk_lo [STACK_DEPTH];
    logic [AW-1:0] r_stk_hi [STACK_DEPTH];

    logic                             push;
    logic [AW-1:0]                    push_lo, push_hi;
    logic signed [hqs_pkg::VAL_W-1:0] cmp_b;
    logic                             ooo;
    logic [AW-1:0]                    dl, dh, s_lo, s_hi;
    logic                             s_ok;

    // the one comparator, shared by partition and insertion
    assign cmp_b = (r_state == hqs_pkg::SS_P_CMP) ? r_pivot : r_key;
    assign ooo   = hqs_pkg::out_of_order(i_ram_rdata, cmp_b, i_desc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hqs_pkg::SS_IDLE;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_ilo    <= n_ilo;
        r_ihi    <= n_ihi;
        r_i      <= n_i;
        r_jp     <= n_jp;
        r_j      <= n_j;
        r_ip     <= n_ip;
        r_pivot  <= n_pivot;
        r_key    <= n_key;
        r_val    <= n_val;
        r_resume <= n_resume;
        if (push) begin
            r_stk_lo[r_sp[SIW-1:0]] <= push_lo;
            r_stk_hi[r_sp[SIW-1:0]] <= push_hi;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_ilo       = r_ilo;
        n_ihi       = r_ihi;
        n_i         = r_i;
        n_jp        = r_jp;
        n_j         = r_j;
        n_ip        = r_ip;
        n_pivot     = r_pivot;
        n_key       = r_key;
        n_val       = r_val;
        n_resume    = r_resume;
        n_sp        = r_sp;
        push        = 1'b0;
        push_lo     = '0;
        push_hi     = '0;
        o_done      = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_hi;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_ip;
        o_ram_wdata = r_pivot;
        dl          = r_ip - r_lo;
        dh          = r_hi - r_ip;
        s_lo        = r_lo;
        s_hi        = r_ip - AW'(1);
        s_ok        = 1'b0;

        case (r_state)
            hqs_pkg::SS_IDLE: begin
                if (i_start) begin
                    n_lo    = '0;
                    n_hi    = AW'(i_count - 1'b1);
                    n_sp    = '0;
                    n_state = hqs_pkg::SS_LOOP;
                end
            end
            hqs_pkg::SS_LOOP: begin
                if (r_lo < r_hi) begin
                    if (XW'(r_hi - r_lo) < CUT) begin
                        n_ilo    = r_lo;
                        n_ihi    = r_hi;
                        n_i      = r_lo + AW'(1);
                        n_resume = 1'b0;
                        n_state  = hqs_pkg::SS_I_RDK;
                    end else begin
                        n_state = hqs_pkg::SS_P_RDP;
                    end
                end else begin
                    n_state = hqs_pkg::SS_POP;
                end
            end
            hqs_pkg::SS_POP: begin
                if (r_sp == '0) begin
                    o_done  = 1'b1;
                    n_state = hqs_pkg::SS_IDLE;
                end else begin
                    n_sp    = r_sp - 1'b1;
                    n_lo    = r_stk_lo[n_sp[SIW-1:0]];
                    n_hi    = r_stk_hi[n_sp[SIW-1:0]];
                    n_state = hqs_pkg::SS_LOOP;
                end
            end
            // Lomuto partition, pivot is the last element
            hqs_pkg::SS_P_RDP: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = r_hi;
                n_state     = hqs_pkg::SS_P_LDP;
            end
            hqs_pkg::SS_P_LDP: begin
                n_pivot = i_ram_rdata;
                n_j     = r_lo;
                n_ip    = r_lo;
                n_state = hqs_pkg::SS_P_RDJ;
            end
            hqs_pkg::SS_P_RDJ: begin
                if (r_j == r_hi) begin
                    n_state = hqs_pkg::SS_F_RD;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_j;
                    n_state     = hqs_pkg::SS_P_CMP;
                end
            end
            hqs_pkg::SS_P_CMP: begin
                if (!ooo) begin
                    if (r_ip == r_j) begin
                        n_ip    = r_ip + AW'(1);
                        n_j     = r_j + AW'(1);
                        n_state = hqs_pkg::SS_P_RDJ;
                    end else begin
                        n_val       = i_ram_rdata;
                        o_ram_re    = 1'b1;
                        o_ram_raddr = r_ip;
                        n_state     = hqs_pkg::SS_P_SW1;
                    end
                end else begin
                    n_j     = r_j + AW'(1);
                    n_state = hqs_pkg::SS_P_RDJ;
                end
            end
            hqs_pkg::SS_P_SW1: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_j;
                o_ram_wdata = i_ram_rdata;
                n_state     = hqs_pkg::SS_P_SW2;
            end
            hqs_pkg::SS_P_SW2: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_ip;
                o_ram_wdata = r_val;
                n_ip        = r_ip + AW'(1);
                n_j         = r_j + AW'(1);
                n_state     = hqs_pkg::SS_P_RDJ;
            end
            // pivot moves into its slot
            hqs_pkg::SS_F_RD: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = r_ip;
                n_state     = hqs_pkg::SS_F_SW1;
            end
            hqs_pkg::SS_F_SW1: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_hi;
                o_ram_wdata = i_ram_rdata;
                n_state     = hqs_pkg::SS_F_SW2;
            end
            hqs_pkg::SS_F_SW2: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_ip;
                o_ram_wdata = r_pivot;
                n_state     = hqs_pkg::SS_SPLIT;
            end
            // smaller side to the stack, keep going on the larger side
            hqs_pkg::SS_SPLIT: begin
                if (dl < dh) begin
                    s_lo = r_lo;
                    s_hi = r_ip - AW'(1);
                    s_ok = dl > AW'(1);
                    n_lo = r_ip + AW'(1);
                end else begin
                    s_lo = r_ip + AW'(1);
                    s_hi = r_hi;
                    s_ok = dh > AW'(1);
                    n_hi = r_ip - AW'(1);
                end
                n_state = hqs_pkg::SS_LOOP;
                if (s_ok) begin
                    if (r_sp < SDEPTH) begin
                        push    = 1'b1;
                        push_lo = s_lo;
                        push_hi = s_hi;
                        n_sp    = r_sp + 1'b1;
                    end else begin
                        // stack full: finish the small side here
                        n_ilo    = s_lo;
                        n_ihi    = s_hi;
                        n_i      = s_lo + AW'(1);
                        n_resume = 1'b1;
                        n_state  = hqs_pkg::SS_I_RDK;
                    end
                end
            end
            // insertion sort over r_ilo..r_ihi
            hqs_pkg::SS_I_RDK: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = r_i;
                n_state     = hqs_pkg::SS_I_LDK;
            end
            hqs_pkg::SS_I_LDK: begin
                n_key   = i_ram_rdata;
                n_jp    = r_i;
                n_state = hqs_pkg::SS_I_RDJ;
            end
            hqs_pkg::SS_I_RDJ: begin
                if (r_jp == r_ilo) begin
                    n_state = hqs_pkg::SS_I_WR;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_jp - AW'(1);
                    n_state     = hqs_pkg::SS_I_CMP;
                end
            end
            hqs_pkg::SS_I_CMP: begin
                if (ooo) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_jp;
                    o_ram_wdata = i_ram_rdata;
                    n_jp        = r_jp - AW'(1);
                    n_state     = hqs_pkg::SS_I_RDJ;
                end else begin
                    n_state = hqs_pkg::SS_I_WR;
                end
            end
            hqs_pkg::SS_I_WR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_jp;
                o_ram_wdata = r_key;
                if (r_i == r_ihi) begin
                    n_state = r_resume ? hqs_pkg::SS_LOOP : hqs_pkg::SS_POP;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = hqs_pkg::SS_I_RDK;
                end
            end
            default: begin
                n_state = hqs_pkg::SS_IDLE;
            end
        endcase
    end

endmodule

@@ tb/tb_hybrid_quicksort_engine.sv @@
// tb_hybrid_quicksort_engine: self-checking bench for the quicksort engine; streams arrays,
// predicts each sorted output array, and checks every result request field by field.
// Depends on hqs_pkg and hybrid_quicksort_engine.
module tb_hybrid_quicksort_engine;

    localparam int VAL_W = hqs_pkg::VAL_W;

    localparam int MAX_ELEMENTS     = 64;
    localparam int INSERTION_CUTOFF = 10;
    localparam int STACK_DEPTH      = 8;

    localparam int STALL_LIMIT   = 100000;  // cycles with no request moving on either side
    localparam int SETTLE_CYCLES = 16;      // block back in load once last result is out
    localparam int LONG_HOLD     = 400;     // receiver hold-off that backs up the input
    localparam int SMALL_BUDGET  = 22;      // small-array requests per phase

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // kind of full-size array that opens each random phase
    typedef enum int {
        BIG_DEEP,       // drives the range stack past its depth
        BIG_OVERFLOW,   // more values than the store holds
        BIG_SORTED      // already in order: degenerate pivots, longest sort
    } t_big_array;

    // ------------------------------------------------------------------
    // Sorted-stream tracker: collects the values of the array being
    // loaded (dropping those past capacity), and on the last request
    // sorts them in the current order and queues the expected results.
    // ------------------------------------------------------------------
    class t_sort_tracker;
        int                       capacity;
        bit                       descending;
        logic signed [VAL_W-1:0]  loading[$];
        logic signed [VAL_W-1:0]  due_value[$];
        bit                       due_last[$];
        int                       errors;
        int                       arrays;
        int                       results;
        int                       dropped;

        function new(int cap);
            capacity = cap;
        endfunction

        function bit goes_after(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b);
            return descending ? (a < b) : (a > b);
        endfunction

        function void note_element(logic signed [VAL_W-1:0] v, bit last);
            logic signed [VAL_W-1:0] key;
            int i;
            int j;
            if (loading.size() < capacity) begin
                loading.push_back(v);
            end else begin
                dropped++;
            end
            if (!last) return;
            // equal values are indistinguishable, so any correct sort
            // of the stored multiset gives the block's output order
            for (i = 1; i < loading.size(); i++) begin
                key = loading[i];
                j = i - 1;
                while (j >= 0 && goes_after(loading[j], key)) begin
                    loading[j + 1] = loading[j];
                    j--;
                end
                loading[j + 1] = key;
            end
            for (i = 0; i < loading.size(); i++) begin
                due_value.push_back(loading[i]);
                due_last.push_back(i == loading.size() - 1);
            end
            arrays++;
            loading.delete();
        endfunction

        function void check_output(logic signed [VAL_W-1:0] v, logic last);
            logic signed [VAL_W-1:0] want_value;
            bit                      want_last;
            results++;
            if (due_value.size() == 0) begin
                $error("unexpected result: sorted_value %0d, last_out %0b", v, last);
                errors++;
                return;
            end
            want_value = due_value.pop_front();
            want_last  = due_last.pop_front();
            if (v !== want_value) begin
                $error("sorted_value: expected %0d, actual %0d", want_value, v);
                errors++;
            end
            if (last !== want_last) begin
                $error("last_out: expected %0b, actual %0b", want_last, last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                     i_clk;
    logic                     i_rst_n    = 1'b0;
    logic                     i_valid    = 1'b0;
    logic                     o_ready;
    logic signed [VAL_W-1:0]  i_value    = '0;
    logic                     i_last_in  = 1'b0;
    logic                     o_valid;
    logic                     i_ready    = 1'b0;
    logic signed [VAL_W-1:0]  o_sorted_value;
    logic                     o_last_out;
    logic                     i_cfg_we   = 1'b0;
    logic                     i_cfg_data = 1'b0;

    t_sort_tracker            tracker;
    logic signed [VAL_W-1:0]  arr_buf[$];       // array about to be sent
    int                       requests_sent = 0;
    bit                       hold_armed    = 1'b0;
    int unsigned              stall_cycles  = 0;

    hybrid_quicksort_engine #(
        .MAX_ELEMENTS     (MAX_ELEMENTS),
        .INSERTION_CUTOFF (INSERTION_CUTOFF),
        .STACK_DEPTH      (STACK_DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .i_last_in      (i_last_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a sort of a full presorted store is the longest quiet
    // stretch (order N^2 compares); the limit is far above that plus the
    // long receiver hold.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // mostly no gap, often short, now and then long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // extremes, a narrow band that makes duplicates, and full-range values
    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return -1;
            endcase
        end
        if (r < 4) return int'($urandom_range(0, 8)) - 4;
        return $urandom;
    endfunction

    task automatic build_random(input int n);
        arr_buf.delete();
        repeat (n) arr_buf.push_back(pick_value());
    endtask

    // Already in the selected order: every Lomuto pivot lands at an end.
    task automatic build_presorted(input bit desc);
        logic signed [VAL_W-1:0] base;
        logic signed [VAL_W-1:0] stride;
        int k;
        base   = $signed($urandom) >>> 2;
        stride = $urandom_range(0, 65535);
        arr_buf.delete();
        for (k = 0; k < MAX_ELEMENTS; k++) begin
            arr_buf.push_back(desc ? base - k * stride : base + k * stride);
        end
    endtask

    // Full store laid out so every partition pivots on rank 2 of its range:
    // the two values ahead of the pivot already sit at the front, so the
    // only real swap moves the pivot forward and pulls the next pivot to the
    // end. Each step pushes a 2-element left side, 18 steps before the range
    // is down to the cutoff, so the range stack overflows.
    task automatic build_deep_partition(input bit desc);
        int                      rank_at[MAX_ELEMENTS];
        int                      k;
        int                      r;
        int                      off;
        logic signed [VAL_W-1:0] base;
        logic signed [VAL_W-1:0] stride;
        r = 0;
        for (k = 0; k < 18; k++) begin
            rank_at[3 * k]     = r;
            rank_at[3 * k + 1] = r + 1;
            rank_at[(k == 0) ? MAX_ELEMENTS - 1 : 3 * k - 1] = r + 2;
            r += 3;
        end
        // tail left for insertion sort: rotated ranks 54..63
        off = $urandom_range(0, 9);
        for (k = 0; k < 10; k++) rank_at[53 + k] = r + (k + off) % 10;
        base   = $signed($urandom) >>> 2;
        stride = $urandom_range(1, 65535);
        arr_buf.delete();
        for (k = 0; k < MAX_ELEMENTS; k++) begin
            arr_buf.push_back(desc ? base - rank_at[k] * stride : base + rank_at[k] * stride);
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Send arr_buf as one array; last_in on its final request. Valid stays
    // high across back-to-back requests and is only lowered for a gap.
    task automatic send_array(input bit burst);
        int idx;
        int gap;
        for (idx = 0; idx < arr_buf.size(); idx++) begin
            gap = burst ? 0 : pick_gap();
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid   <= 1'b1;
            i_value   <= arr_buf[idx];
            i_last_in <= (idx == arr_buf.size() - 1);
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            tracker.note_element(arr_buf[idx], idx == arr_buf.size() - 1);
            requests_sent++;
        end
    endtask

    task automatic wait_drained();
        while (tracker.due_value.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // order bit; only called with the block idle
    task automatic write_order(input bit desc);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= desc;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.descending = desc;
    endtask

    // One setting of the order bit: a full-size array first, then small
    // arrays around the insertion cutoff, then the sender waits for every
    // result before the next write.
    task automatic run_phase(input bit desc, input t_big_array big);
        int budget;
        int n;
        write_order(desc);
        case (big)
            BIG_DEEP:     build_deep_partition(desc);
            BIG_OVERFLOW: build_random(MAX_ELEMENTS + $urandom_range(1, 6));
            default:      build_presorted(desc);
        endcase
        send_array($urandom_range(0, 3) == 0);
        budget = requests_sent + SMALL_BUDGET;
        while (requests_sent < budget) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(INSERTION_CUTOFF + 1, 24)
                                            : $urandom_range(1, INSERTION_CUTOFF);
            build_random(n);
            send_array($urandom_range(0, 3) == 0);
        end
        i_valid <= 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready gaps with steady stretches; one long hold
    // when armed, so the drain stalls and the next array backs up.
    // ------------------------------------------------------------------
    initial begin
        int gap;
        bit steady;
        steady = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0) steady = !steady;
            if (hold_armed && tracker.due_value.size() != 0) begin
                gap = LONG_HOLD;
                hold_armed = 1'b0;
            end else begin
                gap = steady ? 0 : pick_gap();
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            tracker.check_output(o_sorted_value, o_last_out);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        tracker = new(MAX_ELEMENTS);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one-element arrays at the extremes, bit patterns,
        // and a cutoff-sized array with duplicates
        write_order(1'b0);
        arr_buf = '{VAL_MIN};                                   send_array(1'b0);
        arr_buf = '{VAL_MAX};                                   send_array(1'b1);
        arr_buf = '{32'sd0};                                    send_array(1'b0);
        arr_buf = '{-32'sd1};                                   send_array(1'b0);
        arr_buf = '{VAL_MAX, VAL_MIN, 32'sh5555_5555, 32'shAAAA_AAAA};
        send_array(1'b1);
        arr_buf = '{32'sd5, -32'sd1, 32'sd5, VAL_MIN, 32'sd0,
                    VAL_MAX, -32'sd1, 32'sd5, 32'sd2, -32'sd2};
        send_array(1'b0);
        i_valid <= 1'b0;
        wait_drained();

        // random phases, order bit alternating
        run_phase(1'b0, BIG_DEEP);
        hold_armed = 1'b1;
        run_phase(1'b1, BIG_DEEP);
        run_phase(1'b0, BIG_OVERFLOW);
        run_phase(1'b1, BIG_SORTED);

        $display("Sorted %0d arrays: %0d values in, %0d dropped past capacity, %0d out.",
                 tracker.arrays, requests_sent, tracker.dropped, tracker.results);
        $display("Both orders; stack-overflow, presorted and overfull %0d-deep arrays.",
                 MAX_ELEMENTS);
        if (tracker.errors == 0 && tracker.due_value.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/hqs_pkg.sv
src/hqs_ram.sv
src/hqs_sorter.sv
src/hybrid_quicksort_engine.sv
tb/tb_hybrid_quicksort_engine.sv
